// ===== design/assert_macros.svh =====
// assertion macros used by the checksum engine controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property check, disabled during reset
`define PC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// same-cycle implication
`define PC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define PC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define PC_ASSERT(lbl, clk, rst, prop)
`define PC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/pcksum_pkg.sv =====
// types, constants and byte-step functions of the checksum engine
package pcksum_pkg;

  localparam int COUNT_BITS = 48;
  localparam int TOTAL_W    = 48;
  localparam int SUM_W      = 32;
  localparam int OUT_W      = 3 * SUM_W + TOTAL_W;

  localparam logic [31:0] CKSUM_POLY      = 32'h04C11DB7;
  localparam logic [31:0] ZLIB_POLY       = 32'hEDB88320;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [15:0] ADLER_LOW_RESET = 16'd1;
  localparam logic [2:0]  ENABLE_RESET    = 3'd7;

  localparam int EN_CKSUM = 0;
  localparam int EN_CRC32 = 1;
  localparam int EN_ADLER = 2;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_DATA   = 2'd1,
    FUNC_FINISH = 2'd2
  } func_t;

  typedef struct packed {
    logic clear;     // restore reset values of all sums
    logic data;      // fold the input byte into the sums
    logic fin_load;  // load the length shifter from the byte counter
    logic fin_inv;   // invert the cksum crc right away (empty count)
    logic feed;      // fold one length byte into the cksum crc
    logic out_load;  // capture the current sums into the output register
  } cmd_t;

  typedef struct packed {
    logic cksum_en;  // cksum accumulation enabled
    logic cnt_zero;  // byte counter is zero
    logic len_last;  // remaining length is zero after this byte
  } status_t;

  // msb-first crc step over one byte
  function automatic logic [31:0] cksum_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {b, 24'h000000};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ((r << 1) ^ CKSUM_POLY) : (r << 1);
    end
    return r;
  endfunction

  // reflected crc-32 step over one byte, pre and post inverted
  function automatic logic [31:0] zlib_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = ~crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ ZLIB_POLY) : (r >> 1);
    end
    return ~r;
  endfunction

endpackage

// ===== design/pcksum_ctrl.sv =====
// controller: command sequencing, finish iteration and output handshake
`include "assert_macros.svh"

module pcksum_ctrl
  import pcksum_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  func,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_final,
  input  status_t     status,
  output cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FEED = 2'b10
  } state_t;

  state_t st, st_next;
  logic   pend, pend_next;
  logic   pend_final, pend_final_next;
  logic   out_valid, out_valid_next;
  logic   out_final;
  logic   accept, feed_done, pend_set;
  logic   is_start, is_data, is_finish;

  always_comb begin
    is_start  = (func == FUNC_START);
    is_data   = (func == FUNC_DATA);
    is_finish = (func == FUNC_FINISH);

    cmd.out_load = pend && (!out_valid || m_tready);
    s_tready     = (st == ST_IDLE) && (!pend || cmd.out_load);
    accept       = s_tvalid && s_tready;

    cmd.clear    = accept && is_start;
    cmd.data     = accept && is_data;
    cmd.fin_load = accept && is_finish && status.cksum_en && !status.cnt_zero;
    cmd.fin_inv  = accept && is_finish && status.cksum_en && status.cnt_zero;
    cmd.feed     = (st == ST_FEED);

    feed_done = cmd.feed && status.len_last;
    pend_set  = (accept && !cmd.fin_load) || feed_done;

    st_next = st;
    case (st)
      ST_IDLE: begin
        if (cmd.fin_load) st_next = ST_FEED;
      end
      ST_FEED: begin
        if (status.len_last) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase

    pend_next = pend;
    if (pend_set) begin
      pend_next = 1'b1;
    end else if (cmd.out_load) begin
      pend_next = 1'b0;
    end

    pend_final_next = pend_final;
    if (accept) begin
      pend_final_next = is_finish;
    end else if (feed_done) begin
      pend_final_next = 1'b1;
    end

    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_final <= pend_final_next;
    if (cmd.out_load) out_final <= pend_final;
  end

  assign m_tvalid = out_valid;
  assign m_final  = out_final;

  // a finish walk never starts with an unsent result behind it
  `PC_ASSERT_IMP(a_feed_no_pend, clk, rst, st == ST_FEED, !pend)
  // every accepted transaction leaves a result pending or a walk running
  `PC_ASSERT_NXT(a_accept_tracked, clk, rst, accept, pend || st == ST_FEED)
  // a pending result is not dropped while the output stalls
  `PC_ASSERT_NXT(a_pend_held, clk, rst, pend && out_valid && !m_tready, pend)

endmodule

// ===== design/pcksum_dp.sv =====
// datapath: checksum accumulators, byte counter, length shifter, output register
module pcksum_dp
  import pcksum_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  input  logic [7:0]       data_byte,
  input  cmd_t             cmd,
  output status_t          status,
  output logic [OUT_W-1:0] out_data
);

  logic [2:0]            enable_mask;
  logic [31:0]           posix_crc;
  logic [31:0]           zlib_crc;
  logic [15:0]           adler_low;
  logic [15:0]           adler_high;
  logic [COUNT_BITS-1:0] byte_counter;
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] len_shift;

  logic [7:0]  ck_byte;
  logic [31:0] ck_res;
  logic [31:0] zl_res;
  logic [16:0] a_sum, a_mod, h_sum, h_mod;

  always_comb begin
    // one shared cksum byte unit: stream bytes, or length bytes during finish
    ck_byte = cmd.feed ? len[7:0] : data_byte;
    ck_res  = cksum_byte(posix_crc, ck_byte);
    zl_res  = zlib_byte(zlib_crc, data_byte);

    a_sum = {1'b0, adler_low} + {9'd0, data_byte};
    a_mod = (a_sum >= ADLER_MOD) ? (a_sum - ADLER_MOD) : a_sum;
    h_sum = {1'b0, adler_high} + a_mod;
    h_mod = (h_sum >= ADLER_MOD) ? (h_sum - ADLER_MOD) : h_sum;

    len_shift = len >> 8;

    status.cksum_en = enable_mask[EN_CKSUM];
    status.cnt_zero = (byte_counter == '0);
    status.len_last = (len_shift == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= ENABLE_RESET;
      posix_crc    <= '0;
      zlib_crc     <= '0;
      adler_low    <= ADLER_LOW_RESET;
      adler_high   <= '0;
      byte_counter <= '0;
    end else begin
      if (cfg_wr_en) enable_mask <= cfg_wr_data;
      if (cmd.clear) begin
        posix_crc    <= '0;
        zlib_crc     <= '0;
        adler_low    <= ADLER_LOW_RESET;
        adler_high   <= '0;
        byte_counter <= '0;
      end
      if (cmd.data) begin
        if (enable_mask[EN_CKSUM]) posix_crc <= ck_res;
        if (enable_mask[EN_CRC32]) zlib_crc <= zl_res;
        if (enable_mask[EN_ADLER]) begin
          adler_low  <= a_mod[15:0];
          adler_high <= h_mod[15:0];
        end
        byte_counter <= byte_counter + COUNT_BITS'(1);
      end
      if (cmd.fin_inv) posix_crc <= ~posix_crc;
      if (cmd.feed) posix_crc <= status.len_last ? ~ck_res : ck_res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      len <= byte_counter;
    end else if (cmd.feed) begin
      len <= len_shift;
    end
    if (cmd.out_load) begin
      out_data <= {TOTAL_W'(byte_counter), adler_high, adler_low, zlib_crc, posix_crc};
    end
  end

endmodule

// ===== design/posix_cksum_crc_adler_engine_top.sv =====
// top level of the streaming cksum / crc-32 / adler-32 engine
// Streaming checksum engine. Each input transaction carries a command in
// s_tuser (0 start, 1 data byte, 2 finish) and a byte in s_tdata, and yields
// exactly one result transaction with the posix cksum crc, the reflected
// crc-32, the adler-32 and the byte count, plus a final flag in m_tuser.
// Start, data and unused commands may follow back to back at one transaction
// per cycle while the output takes the results. A finish with cksum enabled
// passes each significant byte of the byte count (at most COUNT_BITS/8 = 6)
// through the single shared cksum byte unit and takes no new command until
// the last one is through; with an empty count or cksum disabled it is taken
// like any other command. Results go through an output register, so one
// further command is taken while a result waits downstream. The user must
// write enable_mask through cfg_wr_en / cfg_wr_data only while the engine is
// idle (not enforced by the block); the mask applies from the next byte.
module posix_cksum_crc_adler_engine_top
  import pcksum_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,  // enable_mask
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,      // data_byte[7:0]
  input  logic [1:0]       s_tuser,      // func[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,      // cksum_value, crc32_value, adler32_value, byte_total
  output logic             m_tuser       // is_final
);

  cmd_t    cmd;
  status_t status;

  pcksum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_final  (m_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  pcksum_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_byte   (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_data    (m_tdata)
  );

endmodule

// ===== verif/posix_cksum_crc_adler_engine_checker.sv =====
// checker for the cksum engine: predicts the sums and compares each result
`timescale 1ns / 1ps

module posix_cksum_crc_adler_engine_checker
  import pcksum_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             m_tuser,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [47:0] total;
    logic [31:0] adler;
    logic [31:0] crc32;
    logic [31:0] cksum;
    logic        fin;
  } sums_t;

  logic [2:0]  en_mask;
  logic [31:0] cksum_acc;
  logic [31:0] crc32_acc;
  logic [15:0] adler_a;
  logic [15:0] adler_b;
  logic [47:0] byte_count;
  sums_t       sums_q[$];

  function automatic logic [31:0] cksum_fold(input logic [31:0] crc, input logic [7:0] val);
    logic [31:0] r;
    r = crc ^ {val, 24'h0};
    for (int i = 0; i < 8; i++) begin
      if (r[31]) r = {r[30:0], 1'b0} ^ CKSUM_POLY;
      else r = {r[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] val);
    logic [31:0] r;
    r = ~crc ^ {24'h0, val};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = {1'b0, r[31:1]} ^ ZLIB_POLY;
      else r = {1'b0, r[31:1]};
    end
    return ~r;
  endfunction

  task automatic clear_sums();
    cksum_acc  = '0;
    crc32_acc  = '0;
    adler_a    = ADLER_LOW_RESET;
    adler_b    = '0;
    byte_count = '0;
  endtask

  // update the running sums for one accepted command and queue what should come out
  task automatic apply_command(input logic [1:0] op, input logic [7:0] val);
    logic [16:0] a_sum;
    logic [16:0] b_sum;
    logic [47:0] len;
    logic [31:0] crc;
    sums_t       exp_sums;
    exp_sums.fin = 1'b0;
    case (op)
      FUNC_START: clear_sums();
      FUNC_DATA: begin
        if (en_mask[EN_CKSUM]) cksum_acc = cksum_fold(cksum_acc, val);
        if (en_mask[EN_CRC32]) crc32_acc = crc32_fold(crc32_acc, val);
        if (en_mask[EN_ADLER]) begin
          a_sum = {1'b0, adler_a} + {9'b0, val};
          if (a_sum >= ADLER_MOD) a_sum = a_sum - ADLER_MOD;
          b_sum = {1'b0, adler_b} + a_sum;
          if (b_sum >= ADLER_MOD) b_sum = b_sum - ADLER_MOD;
          adler_a = a_sum[15:0];
          adler_b = b_sum[15:0];
        end
        byte_count = byte_count + 48'd1;
      end
      FUNC_FINISH: begin
        // length goes in low byte first, only as many bytes as it needs
        if (en_mask[EN_CKSUM]) begin
          len = byte_count;
          crc = cksum_acc;
          while (len != 0) begin
            crc = cksum_fold(crc, len[7:0]);
            len = len >> 8;
          end
          cksum_acc = ~crc;
        end
        exp_sums.fin = 1'b1;
      end
      default: ;
    endcase
    exp_sums.cksum = cksum_acc;
    exp_sums.crc32 = crc32_acc;
    exp_sums.adler = {adler_b, adler_a};
    exp_sums.total = byte_count;
    sums_q.push_back(exp_sums);
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_val,
                             input logic [47:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  task automatic check_result();
    sums_t exp_sums;
    if (sums_q.size() == 0) begin
      $error("result transaction with nothing expected: m_tdata %h", m_tdata);
      fail_count++;
    end else begin
      exp_sums = sums_q.pop_front();
      check_field("cksum_value", {16'h0, exp_sums.cksum}, {16'h0, m_tdata[31:0]});
      check_field("crc32_value", {16'h0, exp_sums.crc32}, {16'h0, m_tdata[63:32]});
      check_field("adler32_value", {16'h0, exp_sums.adler}, {16'h0, m_tdata[95:64]});
      check_field("byte_total", exp_sums.total, m_tdata[143:96]);
      check_field("is_final", {47'h0, exp_sums.fin}, {47'h0, m_tuser});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      en_mask = ENABLE_RESET;
      clear_sums();
      sums_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      // a transaction at the write edge still sees the old mask
      if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata);
      if (cfg_wr_en) en_mask = cfg_wr_data;
    end
    pending = sums_q.size();
  end

endmodule

// ===== verif/posix_cksum_crc_adler_engine_top_tb.sv =====
// testbench top for the cksum engine: stimulus, flow control and verdict
`timescale 1ns / 1ps

module posix_cksum_crc_adler_engine_top_tb;
  import pcksum_pkg::*;

  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         PHASE_ITEMS    = 65;
  localparam int         LONG_STREAM    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] MASK_PLAN [8]  = '{3'b000, 3'b001, 3'b010, 3'b100,
                                             3'b101, 3'b011, 3'b110, 3'b111};

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE,
    RX_PERIODIC
  } rx_mode_t;

  logic             clk;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [2:0]       cfg_wr_data = 3'b000;
  logic             s_tvalid    = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata     = 8'h00;  // data_byte[7:0]
  logic [1:0]       s_tuser     = 2'b00;  // func[1:0]
  logic             m_tvalid;
  logic             m_tready    = 1'b0;
  logic [OUT_W-1:0] m_tdata;              // cksum, crc32, adler32, byte_total
  logic             m_tuser;              // is_final

  int       fail_count;
  int       pending;
  int       burst_left = 0;
  int       n_items    = 0;
  int       n_start    = 0;
  int       n_data     = 0;
  int       n_finish   = 0;
  int       n_unused   = 0;
  int       n_cfg      = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       rx_tick    = 0;

  posix_cksum_crc_adler_engine_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  posix_cksum_crc_adler_engine_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // one command transaction; gaps come only between bursts
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    // tready is settled by the falling edge, so the next rising edge takes it
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    burst_left--;
    n_items++;
    case (op)
      FUNC_START:  n_start++;
      FUNC_DATA:   n_data++;
      FUNC_FINISH: n_finish++;
      default:     n_unused++;
    endcase
  endtask

  task automatic send_stream(input int nbytes);
    send_cmd(FUNC_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 15) == 0) send_cmd(FUNC_UNUSED, 8'($urandom_range(0, 255)));
      send_cmd(FUNC_DATA, 8'($urandom_range(0, 255)));
    end
    send_cmd(FUNC_FINISH, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) send_cmd(FUNC_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_mask(input logic [2:0] mask);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    // extra margin: a finish still feeding length bytes keeps its result pending
    repeat (10) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  task automatic run_phase(input int budget);
    int first;
    int nbytes;
    first = n_items;
    // bytes without a start first, so the new mask lands mid-stream
    repeat ($urandom_range(1, 4)) send_cmd(FUNC_DATA, 8'($urandom_range(0, 255)));
    while (n_items - first < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        nbytes = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
        send_stream(nbytes);
      end else begin
        repeat ($urandom_range(1, 5))
          send_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver flow control: switches between open, random, choked and periodic
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RX_CHOKE:    m_tready <= ($urandom_range(0, 7) == 0);
      RX_PERIODIC: m_tready <= (rx_tick % 5) != 0;
      default:     m_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results pending",
               idle_cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, repeated finish, unused code, empty count
    send_cmd(FUNC_START, 8'hFF);
    send_cmd(FUNC_DATA, 8'h00);
    send_cmd(FUNC_DATA, 8'hFF);
    send_cmd(FUNC_DATA, 8'h80);
    send_cmd(FUNC_DATA, 8'h01);
    send_cmd(FUNC_DATA, 8'h5A);
    send_cmd(FUNC_DATA, 8'hA5);
    send_cmd(FUNC_FINISH, 8'hFF);
    send_cmd(FUNC_FINISH, 8'h00);
    send_cmd(FUNC_UNUSED, 8'hFF);
    send_cmd(FUNC_DATA, 8'h7E);
    send_cmd(FUNC_FINISH, 8'h00);
    send_cmd(FUNC_START, 8'h00);
    send_cmd(FUNC_FINISH, 8'h00);
    send_cmd(FUNC_UNUSED, 8'h00);
    send_cmd(FUNC_START, 8'h00);
    send_cmd(FUNC_DATA, 8'hFF);
    send_cmd(FUNC_DATA, 8'hFF);
    send_cmd(FUNC_FINISH, 8'hAA);

    // one stream long enough for a two-byte length in the cksum trailer
    write_mask(3'b111);
    send_stream(LONG_STREAM);
    run_phase(PHASE_ITEMS);
    for (int i = 0; i < 8; i++) begin
      write_mask(MASK_PLAN[i]);
      run_phase(PHASE_ITEMS);
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (16) @(negedge clk);

    $display("summary: %0d commands: %0d start, %0d data, %0d finish, %0d unused code",
             n_items, n_start, n_data, n_finish, n_unused);
    $display("summary: %0d enable_mask writes, including all-off and all-on", n_cfg);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
